>>> sv/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg: shared types and constants for the keypad press classifier
// Holds the item layouts, configuration register map and event codes.
// ----------------------------------------------------------------------------
package kpc_pkg;

  // Key codes
  localparam logic [3:0] KEY_NONE    = 4'd0;
  localparam logic [3:0] KEY_CONFIRM = 4'd12;
  localparam logic [3:0] KEY_CFG     = 4'd13;

  // Event codes (short events reuse the key code itself)
  localparam logic [4:0] EV_NONE        = 5'd0;
  localparam logic [4:0] EV_ENTER_LONG  = 5'd14;
  localparam logic [4:0] EV_CFG_LONG    = 5'd15;
  localparam logic [4:0] EV_LOCKOUT     = 5'd16;

  // Timer reload while a key stays down in wait-release
  localparam logic [7:0] QUICK_RELOAD   = 8'd3;
  localparam logic [7:0] WAIT_COUNT_MAX = 8'd255;

  // Configuration register map
  localparam logic [1:0] CFG_LONG_TICKS    = 2'd0;
  localparam logic [1:0] CFG_REL_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_LOCK_THRESH   = 2'd2;
  localparam logic [1:0] CFG_LONG_MASK     = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_LONG_TICKS  = 8'd31;
  localparam logic [7:0]  RST_REL_TIMEOUT = 8'd125;
  localparam logic [7:0]  RST_LOCK_THRESH = 8'd5;
  localparam logic [13:0] RST_LONG_MASK   = 14'h3000;

  typedef struct packed {
    logic [3:0] key_code;
    logic       holdoff;
    logic [7:0] error_count;
  } kpc_item_t;

  typedef struct packed {
    logic [4:0] event_code;
    logic       light_request;
    logic [3:0] light_index;
    logic       touch_reinit;
    logic       is_idle;
  } kpc_result_t;

  typedef struct packed {
    logic [7:0]  long_press_ticks;
    logic [7:0]  release_timeout_ticks;
    logic [7:0]  lockout_threshold;
    logic [13:0] long_enable_mask;
  } kpc_cfg_t;

endpackage

>>> sv/kpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// kpc_cfg_regs: configuration register bank
// Four registers written through a valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module kpc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [13:0]       wr_data,
  output kpc_pkg::kpc_cfg_t cfg
);
  import kpc_pkg::*;

  kpc_cfg_t cfg_r;

  // Write the addressed register, restore defaults on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks      <= RST_LONG_TICKS;
      cfg_r.release_timeout_ticks <= RST_REL_TIMEOUT;
      cfg_r.lockout_threshold     <= RST_LOCK_THRESH;
      cfg_r.long_enable_mask      <= RST_LONG_MASK;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_LONG_TICKS:  cfg_r.long_press_ticks      <= wr_data[7:0];
        CFG_REL_TIMEOUT: cfg_r.release_timeout_ticks <= wr_data[7:0];
        CFG_LOCK_THRESH: cfg_r.lockout_threshold     <= wr_data[7:0];
        CFG_LONG_MASK:   cfg_r.long_enable_mask      <= wr_data;
        default:         cfg_r.long_enable_mask      <= cfg_r.long_enable_mask;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/kpc_core.sv
// ----------------------------------------------------------------------------
// kpc_core: press state machine and event classification
// Computes one result per item from the registered item and the state, and
// advances the state when the item moves on to the result register.
// ----------------------------------------------------------------------------
module kpc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  kpc_pkg::kpc_item_t   item,
  input  kpc_pkg::kpc_cfg_t    cfg,
  output kpc_pkg::kpc_result_t result
);
  import kpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ONCE     = 2'd1,
    ST_PRESSING = 2'd2,
    ST_WAIT     = 2'd3
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  held_key_r, held_key_nxt;
  logic [7:0]  press_timer_r, press_timer_nxt;
  logic [7:0]  wait_cnt_r, wait_cnt_nxt;

  logic [3:0]  key;
  logic [7:0]  timer_dec;
  logic [7:0]  wait_inc;
  logic        long_capable;
  logic        short_ev;
  logic [3:0]  short_key;
  kpc_result_t res;

  // Fold unused key codes to no key, count the press timer down
  assign key          = (item.key_code > KEY_CFG) ? KEY_NONE : item.key_code;
  assign timer_dec    = (press_timer_r != 8'd0) ? press_timer_r - 8'd1 : 8'd0;
  assign wait_inc     = (wait_cnt_r != WAIT_COUNT_MAX) ? wait_cnt_r + 8'd1 : wait_cnt_r;
  assign long_capable = (held_key_r <= KEY_CFG) && cfg.long_enable_mask[held_key_r];

  // Next state and event for this item
  always_comb begin
    state_nxt       = state_r;
    held_key_nxt    = held_key_r;
    press_timer_nxt = press_timer_r;
    wait_cnt_nxt    = wait_cnt_r;
    short_ev        = 1'b0;
    short_key       = held_key_r;
    res             = '0;
    if (!item.holdoff) begin
      press_timer_nxt = timer_dec;
      unique case (state_r)
        ST_IDLE: begin
          if (key != KEY_NONE) begin
            state_nxt    = ST_ONCE;
            held_key_nxt = key;
          end
        end
        ST_ONCE: begin
          if (held_key_r != key) begin
            state_nxt = ST_IDLE;
          end else if (item.error_count >= cfg.lockout_threshold) begin
            res.event_code = EV_LOCKOUT;
            state_nxt      = ST_WAIT;
          end else begin
            press_timer_nxt = cfg.long_press_ticks;
            if (long_capable) begin
              state_nxt = ST_PRESSING;
            end else begin
              state_nxt = ST_WAIT;
              short_ev  = 1'b1;
            end
          end
        end
        ST_PRESSING: begin
          if (timer_dec == 8'd0 && held_key_r == key) begin
            state_nxt = ST_WAIT;
            if (held_key_r == KEY_CONFIRM) begin
              res.event_code = EV_ENTER_LONG;
            end else if (held_key_r == KEY_CFG) begin
              res.event_code = EV_CFG_LONG;
            end
          end else if (key == KEY_NONE) begin
            state_nxt = ST_IDLE;
            short_ev  = 1'b1;
          end
        end
        ST_WAIT: begin
          wait_cnt_nxt = wait_inc;
          if (wait_inc >= cfg.release_timeout_ticks) begin
            res.touch_reinit = 1'b1;
            wait_cnt_nxt     = 8'd0;
            state_nxt        = ST_IDLE;
          end
          if (held_key_r == key) begin
            if (timer_dec == 8'd0) begin
              press_timer_nxt = QUICK_RELOAD;
            end
          end else begin
            wait_cnt_nxt = 8'd0;
            state_nxt    = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
    // Short event: key code as event, flash its light unless it is config
    if (short_ev) begin
      res.event_code = {1'b0, short_key};
      if (short_key != KEY_CFG && short_key != KEY_NONE) begin
        res.light_request = 1'b1;
        res.light_index   = short_key - 4'd1;
      end
    end
    res.is_idle = (state_nxt == ST_IDLE);
  end

  assign result = res;

  // Advance state as the item leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      held_key_r    <= 4'd0;
      press_timer_r <= 8'd0;
      wait_cnt_r    <= 8'd0;
    end else if (step_en) begin
      state_r       <= state_nxt;
      held_key_r    <= held_key_nxt;
      press_timer_r <= press_timer_nxt;
      wait_cnt_r    <= wait_cnt_nxt;
    end
  end

endmodule

>>> sv/kpc_out_reg.sv
// ----------------------------------------------------------------------------
// kpc_out_reg: result register
// Holds one result item for the output channel and reports when it can load.
// ----------------------------------------------------------------------------
module kpc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_en,
  input  kpc_pkg::kpc_result_t load_data,
  output logic                 can_load,
  input  logic                 out_ready,
  output logic                 out_valid,
  output kpc_pkg::kpc_result_t out_data
);
  import kpc_pkg::*;

  logic        valid_r;
  kpc_result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Hold the item until taken, load the next one in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_en) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= load_data;
    end
  end

endmodule

>>> sv/keypad_press_classifier.sv
// ----------------------------------------------------------------------------
// keypad_press_classifier: key debounce with short and long press events
// Input register, press state machine and result register in one pass.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                             | direction
//  ---------+---------------------------------------------------+----------
//  in       | in_valid/in_ready, key_code, holdoff, error_count | to block
//  out      | out_valid/out_ready, event_code ... is_idle       | from block
//  cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data          | to block
//
// One item per clock cycle sustained while the output is not stalled; each item
// passes the input register and then the result register.
// Synchronous active-low reset returns the state machine to idle and the
// configuration registers to their defaults. A stalled output holds its item
// while the input register still takes one more item.
// ----------------------------------------------------------------------------
module keypad_press_classifier (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_key_code,
  input  logic        in_holdoff,
  input  logic [7:0]  in_error_count,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_event_code,
  output logic        out_light_request,
  output logic [3:0]  out_light_index,
  output logic        out_touch_reinit,
  output logic        out_is_idle,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);
  import kpc_pkg::*;

  logic        in_valid_r;
  kpc_item_t   in_item_r;
  logic        step_en;
  logic        can_load;
  kpc_cfg_t    cfg;
  kpc_result_t core_res;
  kpc_result_t out_res;

  assign cfg_ready = 1'b1;

  kpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the registered item on whenever the result register can take it
  assign step_en  = in_valid_r && can_load;
  assign in_ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.key_code    <= in_key_code;
      in_item_r.holdoff     <= in_holdoff;
      in_item_r.error_count <= in_error_count;
    end
  end

  kpc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (core_res)
  );

  kpc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (step_en),
    .load_data (core_res),
    .can_load  (can_load),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_res)
  );

  assign out_event_code    = out_res.event_code;
  assign out_light_request = out_res.light_request;
  assign out_light_index   = out_res.light_index;
  assign out_touch_reinit  = out_res.touch_reinit;
  assign out_is_idle       = out_res.is_idle;

`ifndef SYNTHESIS
  // A reinit pulse comes with no event and leaves the machine idle
  a_reinit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_touch_reinit |-> out_is_idle && out_event_code == EV_NONE)
    else $error("touch reinit without idle or with an event");

  // A light request names the key of its short event
  a_light_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_light_request |->
      out_event_code == {1'b0, out_light_index + 4'd1} && out_event_code < 5'd13)
    else $error("light request does not match short event");

  // A full pipeline with a stalled output refuses new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full");

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code))
    else $error("stalled result changed");
`endif

endmodule

>>> sim/kpc_event_checker.sv
// ----------------------------------------------------------------------------
// kpc_event_checker: result prediction and comparison for the press classifier
// Watches the configuration, tick and result channels of the block. Keeps its
// own copy of the press state machine and settings, works out the result of
// every accepted tick and compares each accepted result with the oldest one
// still due. Reports the number of results still due and the failure count.
// ----------------------------------------------------------------------------
module kpc_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  // tick channel
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_key_code,
  input  logic        in_holdoff,
  input  logic [7:0]  in_error_count,
  // result channel
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  out_event_code,
  input  logic        out_light_request,
  input  logic [3:0]  out_light_index,
  input  logic        out_touch_reinit,
  input  logic        out_is_idle,
  // configuration writes
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  // status towards the testbench top
  output int          outstanding,
  output int          fail_count
);
  import kpc_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_ONCE,
    SCAN_PRESSING,
    SCAN_WAIT
  } scan_t;

  kpc_cfg_t     settings;
  scan_t        scan_st;
  logic [3:0]   latched_key;
  logic [7:0]   hold_timer;
  logic [7:0]   release_wait;
  kpc_result_t  due_events[$];
  int           results_seen = 0;
  int           bad_events = 0;

  assign fail_count = bad_events;

  // Short press: event is the key itself, light flashes for all but config
  function automatic kpc_result_t short_press(input logic [3:0] key);
    kpc_result_t r;
    r = '0;
    r.event_code = {1'b0, key};
    if (key != KEY_CFG && key != KEY_NONE) begin
      r.light_request = 1'b1;
      r.light_index   = key - 4'd1;
    end
    return r;
  endfunction

  // Advance the press state machine by one scan tick and give its result
  function automatic kpc_result_t classify_tick(input logic [3:0] key_in,
                                                input logic       hold,
                                                input logic [7:0] errs);
    kpc_result_t r;
    logic [3:0]  key;
    r   = '0;
    key = key_in;
    if (!hold) begin
      // codes above config count as no key
      if (key > KEY_CFG) key = KEY_NONE;
      if (hold_timer != 8'd0) hold_timer = hold_timer - 8'd1;
      case (scan_st)
        SCAN_IDLE: begin
          if (key != KEY_NONE) begin
            scan_st     = SCAN_ONCE;
            latched_key = key;
          end
        end
        SCAN_ONCE: begin
          if (latched_key != key) begin
            scan_st = SCAN_IDLE;
          end else if (errs >= settings.lockout_threshold) begin
            r.event_code = EV_LOCKOUT;
            scan_st      = SCAN_WAIT;
          end else begin
            hold_timer = settings.long_press_ticks;
            if (settings.long_enable_mask[latched_key]) begin
              scan_st = SCAN_PRESSING;
            end else begin
              scan_st = SCAN_WAIT;
              r       = short_press(latched_key);
            end
          end
        end
        SCAN_PRESSING: begin
          // held long enough: long event where one exists, else silent
          if (hold_timer == 8'd0 && latched_key == key) begin
            scan_st = SCAN_WAIT;
            if (latched_key == KEY_CONFIRM) r.event_code = EV_ENTER_LONG;
            else if (latched_key == KEY_CFG) r.event_code = EV_CFG_LONG;
          end else if (key == KEY_NONE) begin
            scan_st = SCAN_IDLE;
            r       = short_press(latched_key);
          end
        end
        default: begin
          if (release_wait != WAIT_COUNT_MAX) release_wait = release_wait + 8'd1;
          if (release_wait >= settings.release_timeout_ticks) begin
            r.touch_reinit = 1'b1;
            release_wait   = 8'd0;
            scan_st        = SCAN_IDLE;
          end
          if (latched_key == key) begin
            if (hold_timer == 8'd0) hold_timer = QUICK_RELOAD;
          end else begin
            release_wait = 8'd0;
            scan_st      = SCAN_IDLE;
          end
        end
      endcase
    end
    r.is_idle = (scan_st == SCAN_IDLE);
    return r;
  endfunction

  // Track settings, predict on every accepted tick, compare every result
  always @(posedge clk) begin : track
    kpc_result_t seen;
    kpc_result_t want;
    if (!rst_n) begin
      settings     = '{RST_LONG_TICKS, RST_REL_TIMEOUT, RST_LOCK_THRESH, RST_LONG_MASK};
      scan_st      = SCAN_IDLE;
      latched_key  = KEY_NONE;
      hold_timer   = 8'd0;
      release_wait = 8'd0;
      due_events.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LONG_TICKS:  settings.long_press_ticks      = cfg_data[7:0];
          CFG_REL_TIMEOUT: settings.release_timeout_ticks = cfg_data[7:0];
          CFG_LOCK_THRESH: settings.lockout_threshold     = cfg_data[7:0];
          CFG_LONG_MASK:   settings.long_enable_mask      = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = '{out_event_code, out_light_request, out_light_index,
                 out_touch_reinit, out_is_idle};
        results_seen++;
        if (due_events.size() == 0) begin
          bad_events++;
          if (bad_events <= 10)
            $display("result %0d with no tick outstanding: %s",
                     results_seen,
                     $sformatf("ev=%0d lr=%0b li=%0d tr=%0b idle=%0b",
                               seen.event_code, seen.light_request,
                               seen.light_index, seen.touch_reinit,
                               seen.is_idle));
        end else begin
          want = due_events.pop_front();
          if (want.event_code !== seen.event_code ||
              want.light_request !== seen.light_request ||
              want.light_index !== seen.light_index ||
              want.touch_reinit !== seen.touch_reinit ||
              want.is_idle !== seen.is_idle) begin
            bad_events++;
            if (bad_events <= 10) begin
              $display("result %0d differs: exp ev=%0d lr=%0b li=%0d tr=%0b idle=%0b",
                       results_seen, want.event_code, want.light_request,
                       want.light_index, want.touch_reinit, want.is_idle);
              $display("  got ev=%0d lr=%0b li=%0d tr=%0b idle=%0b",
                       seen.event_code, seen.light_request, seen.light_index,
                       seen.touch_reinit, seen.is_idle);
            end
          end
        end
      end
      if (in_valid && in_ready)
        due_events.push_back(classify_tick(in_key_code, in_holdoff, in_error_count));
      outstanding <= due_events.size();
    end
  end

endmodule

>>> sim/keypad_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// keypad_press_classifier_tb: testbench top for the keypad press classifier
// Drives scan ticks and settings, stalls the result side at random and
// hands checking to kpc_event_checker. A short scripted run covers short,
// long, lockout, timeout and holdoff cases, then several settings phases
// run press sequences with random content and some plain noise.
// ----------------------------------------------------------------------------
module keypad_press_classifier_tb;
  import kpc_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 80;
  localparam int STOP_AFTER  = 5_000_000;

  // Scripted ticks: short, config long, enter short, lockout with holdoff
  // and release timeout, out-of-range key, key change on first press,
  // silent long press with a key change ignored while pressing
  localparam kpc_item_t SCRIPT [25] = '{
    '{4'd3, 1'b0, 8'd0}, '{4'd3, 1'b0, 8'd0}, '{4'd3, 1'b0, 8'd0},
    '{KEY_NONE, 1'b0, 8'd0},
    '{KEY_CFG, 1'b0, 8'd0}, '{KEY_CFG, 1'b0, 8'd0}, '{KEY_CFG, 1'b0, 8'd0},
    '{KEY_CFG, 1'b0, 8'd0}, '{KEY_NONE, 1'b0, 8'd0},
    '{KEY_CONFIRM, 1'b0, 8'd0}, '{KEY_CONFIRM, 1'b0, 8'd0}, '{KEY_NONE, 1'b0, 8'd0},
    '{4'd1, 1'b0, 8'd9}, '{4'd1, 1'b0, 8'd9}, '{4'd1, 1'b1, 8'd9},
    '{4'd1, 1'b0, 8'd0}, '{4'd1, 1'b0, 8'd0},
    '{4'd15, 1'b0, 8'd255},
    '{4'd7, 1'b0, 8'd0}, '{4'd8, 1'b0, 8'd0},
    '{4'd5, 1'b0, 8'd0}, '{4'd5, 1'b0, 8'd0}, '{4'd6, 1'b0, 8'd0},
    '{4'd5, 1'b0, 8'd0}, '{KEY_NONE, 1'b0, 8'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_key_code = KEY_NONE;
  logic        in_holdoff = 1'b0;
  logic [7:0]  in_error_count = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_event_code;
  logic        out_light_request;
  logic [3:0]  out_light_index;
  logic        out_touch_reinit;
  logic        out_is_idle;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_LONG_TICKS;
  logic [13:0] cfg_data = 14'd0;

  int          outstanding;
  int          fail_count;
  kpc_cfg_t    cur_cfg;
  int          ticks_sent = 0;
  int          send_calm = 0;
  int          take_calm = 0;

  keypad_press_classifier u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_code       (in_key_code),
    .in_holdoff        (in_holdoff),
    .in_error_count    (in_error_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_code    (out_event_code),
    .out_light_request (out_light_request),
    .out_light_index   (out_light_index),
    .out_touch_reinit  (out_touch_reinit),
    .out_is_idle       (out_is_idle),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  kpc_event_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_code       (in_key_code),
    .in_holdoff        (in_holdoff),
    .in_error_count    (in_error_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_code    (out_event_code),
    .out_light_request (out_light_request),
    .out_light_index   (out_light_index),
    .out_touch_reinit  (out_touch_reinit),
    .out_is_idle       (out_is_idle),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .outstanding       (outstanding),
    .fail_count        (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #STOP_AFTER;
    $display("simulation failed");
    $finish;
  end

  // Wait before the next item: mostly a random gap, now and then a calm run with none
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 50);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Offer one tick after a random gap and hold it until accepted
  task automatic send_tick(input logic [3:0] key, input logic hold,
                           input logic [7:0] errs);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_key_code    <= key;
    in_holdoff     <= hold;
    in_error_count <= errs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Write one register; valid is left high for the next write
  task automatic put_reg(input logic [1:0] idx, input logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input kpc_cfg_t c);
    cur_cfg = c;
    put_reg(CFG_LONG_TICKS,  {6'd0, c.long_press_ticks});
    put_reg(CFG_REL_TIMEOUT, {6'd0, c.release_timeout_ticks});
    put_reg(CFG_LOCK_THRESH, {6'd0, c.lockout_threshold});
    put_reg(CFG_LONG_MASK,   c.long_enable_mask);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic end_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // One press: key down for a chosen length with optional noise, then release
  task automatic press_sequence();
    logic [3:0] key;
    logic [7:0] errs;
    int         len;
    int         long_t;
    int         wait_t;
    int         noisy;
    long_t = int'(cur_cfg.long_press_ticks);
    wait_t = int'(cur_cfg.release_timeout_ticks);
    key = 4'($urandom_range(1, 13));
    if ($urandom_range(0, 19) == 0) key = 4'($urandom_range(14, 15));
    if (cur_cfg.lockout_threshold == 8'd0 || $urandom_range(0, 3) == 0)
      errs = 8'($urandom_range(int'(cur_cfg.lockout_threshold), 255));
    else
      errs = 8'($urandom_range(0, int'(cur_cfg.lockout_threshold) - 1));
    // pick bounce, short, about long, or long enough to time out the release
    case ($urandom_range(0, 3))
      0:       len = 1;
      1:       len = $urandom_range(2, 4);
      2:       len = long_t + $urandom_range(1, 3);
      default: begin
        if (key <= KEY_CFG && cur_cfg.long_enable_mask[key])
          len = long_t + wait_t + $urandom_range(2, 4);
        else
          len = wait_t + $urandom_range(2, 4);
        if (len > 300) len = long_t + $urandom_range(1, 3);
      end
    endcase
    noisy = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if (noisy != 0 && $urandom_range(0, 9) == 0)
        send_tick(key, 1'b1, errs);
      else if (noisy != 0 && $urandom_range(0, 9) == 0)
        send_tick(4'($urandom_range(0, 15)), 1'b0, errs);
      else
        send_tick(key, 1'b0, errs);
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 5) == 0)
        send_tick(4'($urandom_range(14, 15)), 1'($urandom), errs);
      else
        send_tick(KEY_NONE, 1'b0, errs);
    end
  endtask

  // Result side: stall at random before taking each item
  initial begin : take_results
    int stall;
    forever begin
      stall = draw_wait(take_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && rst_n)) @(posedge clk);
    end
  end

  // Reset, scripted ticks, then the random settings phases
  initial begin : stimulus
    kpc_cfg_t c;
    int       start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    load_settings('{8'd2, 8'd2, 8'd9, 14'h3020});
    foreach (SCRIPT[i])
      send_tick(SCRIPT[i].key_code, SCRIPT[i].holdoff, SCRIPT[i].error_count);
    end_phase();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: c = '{8'd1, 8'd1, 8'd0, 14'h3FFF};
        1: c = '{8'd255, 8'd255, 8'd255, 14'h0000};
        2: c = '{RST_LONG_TICKS, RST_REL_TIMEOUT, RST_LOCK_THRESH, RST_LONG_MASK};
        default: begin
          c.long_press_ticks = ($urandom_range(0, 4) == 0) ?
                               8'($urandom_range(13, 60)) : 8'($urandom_range(1, 12));
          c.release_timeout_ticks = 8'($urandom_range(1, 24));
          c.lockout_threshold = ($urandom_range(0, 3) == 0) ?
                                8'($urandom_range(0, 255)) : 8'($urandom_range(1, 20));
          c.long_enable_mask = 14'($urandom_range(0, 16383));
        end
      endcase
      load_settings(c);
      start = ticks_sent;
      while (ticks_sent - start < PHASE_TICKS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6))
            send_tick(4'($urandom), 1'($urandom), 8'($urandom));
        end else begin
          press_sequence();
        end
      end
      end_phase();
    end

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
